FILE: rtl/llas_pkg.sv
// ----------------------------------------------------------------------------
// llas_pkg
// shared types and constants for the life-like automaton step core
// ----------------------------------------------------------------------------
package llas_pkg;

    // field and register widths fixed by the interface
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MAX = 3'd4;

    // configuration reset values
    localparam logic [SIZE_W-1:0] RST_ROWS_IN_USE = 7'd64;
    localparam logic [SIZE_W-1:0] RST_COLS_IN_USE = 7'd64;
    localparam logic [CNT_W-1:0]  RST_BIRTH_COUNT = 4'd3;
    localparam logic [CNT_W-1:0]  RST_SURVIVE_MIN = 4'd2;
    localparam logic [CNT_W-1:0]  RST_SURVIVE_MAX = 4'd3;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // birth / survival rule handed to the row evaluator
    typedef struct packed {
        logic [CNT_W-1:0] birth;
        logic [CNT_W-1:0] survive_min;
        logic [CNT_W-1:0] survive_max;
    } t_rule;

endpackage

FILE: rtl/llas_ram.sv
// ----------------------------------------------------------------------------
// llas_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module llas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/llas_row_eval.sv
// ----------------------------------------------------------------------------
// llas_row_eval
// row-wide next-generation logic: counts eight neighbours per cell and
// applies the birth / survival rule
// ----------------------------------------------------------------------------
module llas_row_eval
    import llas_pkg::*;
#(
    parameter int NCOL = 64
) (
    input  logic [NCOL-1:0] i_above,
    input  logic [NCOL-1:0] i_cur,
    input  logic [NCOL-1:0] i_below,
    input  logic [NCOL-1:0] i_mask,
    input  t_rule           i_rule,
    output logic [NCOL-1:0] o_fresh
);

    for (genvar j = 0; j < NCOL; j++) begin : g_cell
        logic             w_al, w_ar, w_cl, w_cr, w_bl, w_br;
        logic [CNT_W-1:0] w_cnt;
        logic             w_next;

        if (j > 0) begin : g_left
            assign w_al = i_above[j-1];
            assign w_cl = i_cur[j-1];
            assign w_bl = i_below[j-1];
        end else begin : g_no_left
            assign w_al = 1'b0;
            assign w_cl = 1'b0;
            assign w_bl = 1'b0;
        end

        if (j < NCOL - 1) begin : g_right
            assign w_ar = i_above[j+1];
            assign w_cr = i_cur[j+1];
            assign w_br = i_below[j+1];
        end else begin : g_no_right
            assign w_ar = 1'b0;
            assign w_cr = 1'b0;
            assign w_br = 1'b0;
        end

        assign w_cnt = CNT_W'(w_al) + CNT_W'(i_above[j]) + CNT_W'(w_ar)
                     + CNT_W'(w_cl) + CNT_W'(w_cr)
                     + CNT_W'(w_bl) + CNT_W'(i_below[j]) + CNT_W'(w_br);

        // live cell survives inside the range, dead cell born on exact match
        assign w_next = i_cur[j] ? ((w_cnt >= i_rule.survive_min) &&
                                    (w_cnt <= i_rule.survive_max))
                                 : (w_cnt == i_rule.birth);

        assign o_fresh[j] = w_next & i_mask[j];
    end

endmodule

FILE: rtl/life_like_automaton_step_core.sv
// ----------------------------------------------------------------------------
// life_like_automaton_step_core
// bounded life-like cellular automaton: write cell, read cell, or advance
// one generation over the grid in use, one row word per memory entry
// ----------------------------------------------------------------------------
// write / read access the grid row, then respond; advance loads, then updates
// each row in use; nop, flagged request or advance over an empty grid respond
// one request at a time; advance throughput is set by the single row-wide
// evaluator walking the grid one row per cycle over the grid memory
// reset: synchronous active low; all cells read dead (per-row valid bits),
// configuration returns to 64 x 64, birth 3, survive 2..3
// ----------------------------------------------------------------------------
module life_like_automaton_step_core
    import llas_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_opcode,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [COL_W-1:0]      i_col,
    input  logic                  i_value,

    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_alive,
    output logic                  o_status,

    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_LOAD,
        S_CALC,
        S_RESP
    } t_state;

    // configuration registers
    logic [SIZE_W-1:0] r_rows_in_use;
    logic [SIZE_W-1:0] r_cols_in_use;
    logic [CNT_W-1:0]  r_birth;
    logic [CNT_W-1:0]  r_smin;
    logic [CNT_W-1:0]  r_smax;

    // sequencer and request context
    t_state            r_state;
    t_opcode           r_op;
    logic [AW-1:0]     r_row;
    logic [CIW-1:0]    r_col;
    logic              r_value;
    logic [SIZE_W-1:0] r_idx;

    // advance window: previous old row (masked) and current old row (full)
    logic [MAX_COLS-1:0] r_above;
    logic [MAX_COLS-1:0] r_cur;

    // pending result and output register
    logic r_alive;
    logic r_status;
    logic r_out_valid;
    logic r_o_alive;
    logic r_o_status;

    // per-row valid bits stand in for clearing the grid at reset
    logic [MAX_ROWS-1:0] r_row_vld;
    logic                r_rd_vld;

    logic [SIZE_W-1:0]   w_eff_rows;
    logic [SIZE_W-1:0]   w_eff_cols;
    logic [MAX_COLS-1:0] w_mask;
    t_rule               w_rule;
    t_opcode             w_op_in;
    logic                w_accept;
    logic                w_out_free;
    logic                w_out_of_range;
    logic                w_has_below;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [MAX_COLS-1:0] w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [MAX_COLS-1:0] w_rdata;
    logic [MAX_COLS-1:0] w_data;
    logic [MAX_COLS-1:0] w_below;
    logic [MAX_COLS-1:0] w_fresh;
    logic [MAX_COLS-1:0] w_cell_word;

    // effective grid size is clipped to the storage
    assign w_eff_rows = (int'(r_rows_in_use) < MAX_ROWS) ? r_rows_in_use
                                                         : SIZE_W'(MAX_ROWS);
    assign w_eff_cols = (int'(r_cols_in_use) < MAX_COLS) ? r_cols_in_use
                                                         : SIZE_W'(MAX_COLS);

    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            w_mask[j] = SIZE_W'(j) < w_eff_cols;
        end
    end

    assign w_rule = '{birth: r_birth, survive_min: r_smin, survive_max: r_smax};

    assign w_op_in    = t_opcode'(i_opcode);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = (r_state == S_IDLE);

    assign w_out_of_range = ({1'b0, i_row} >= w_eff_rows) ||
                            ({1'b0, i_col} >= w_eff_cols);

    // row read this cycle; a row never written reads as all dead
    assign w_data = r_rd_vld ? w_rdata : '0;

    // row below the current one during an advance, dead past the last row
    assign w_has_below = ({1'b0, r_idx} + 8'd1) < {1'b0, w_eff_rows};
    assign w_below     = w_has_below ? (w_data & w_mask) : '0;

    always_comb begin
        w_cell_word        = w_data;
        w_cell_word[r_col] = r_value;
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_row;
        w_wdata = w_cell_word;
        w_raddr = AW'(i_row);
        case (r_state)
            S_IDLE: begin
                if (w_op_in == OP_ADVANCE) begin
                    w_raddr = '0;
                end
            end
            S_ACC: begin
                w_we = (r_op == OP_WRITE);
            end
            S_LOAD: begin
                w_raddr = AW'(r_idx + SIZE_W'(1));
            end
            S_CALC: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_idx);
                w_wdata = (r_cur & ~w_mask) | w_fresh;
                w_raddr = AW'(r_idx + SIZE_W'(2));
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    llas_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    llas_row_eval #(
        .NCOL (MAX_COLS)
    ) u_row_eval (
        .i_above (r_above),
        .i_cur   (r_cur & w_mask),
        .i_below (w_below),
        .i_mask  (w_mask),
        .i_rule  (w_rule),
        .o_fresh (w_fresh)
    );

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rows_in_use <= RST_ROWS_IN_USE;
            r_cols_in_use <= RST_COLS_IN_USE;
            r_birth       <= RST_BIRTH_COUNT;
            r_smin        <= RST_SURVIVE_MIN;
            r_smax        <= RST_SURVIVE_MAX;
            r_row_vld     <= '0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rd_vld <= r_row_vld[w_raddr];

            if (w_we) begin
                r_row_vld[w_waddr] <= 1'b1;
            end

            // configuration request
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data;
                    CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_data;
                    CFG_BIRTH_COUNT: r_birth       <= i_cfg_data[CNT_W-1:0];
                    CFG_SURVIVE_MIN: r_smin        <= i_cfg_data[CNT_W-1:0];
                    CFG_SURVIVE_MAX: r_smax        <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            // result taken; in S_RESP the reload below covers this case
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= w_op_in;
                        r_row    <= AW'(i_row);
                        r_col    <= CIW'(i_col);
                        r_value  <= i_value;
                        r_alive  <= 1'b0;
                        r_idx    <= '0;
                        r_above  <= '0;
                        case (w_op_in)
                            OP_WRITE, OP_READ: begin
                                if (w_out_of_range) begin
                                    r_status <= STATUS_RANGE;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_status <= STATUS_OK;
                                    r_state  <= S_ACC;
                                end
                            end
                            OP_ADVANCE: begin
                                r_status <= STATUS_OK;
                                // empty grid: nothing to walk
                                if (w_eff_rows == '0 || w_eff_cols == '0) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_LOAD;
                                end
                            end
                            default: begin
                                r_status <= STATUS_OK;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ACC: begin
                    // read picks the bit, write is done by the port this cycle
                    if (r_op == OP_READ) begin
                        r_alive <= w_data[r_col];
                    end
                    r_state <= S_RESP;
                end
                S_LOAD: begin
                    r_cur   <= w_data;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    // slide the window down one row
                    r_above <= r_cur & w_mask;
                    r_cur   <= w_data;
                    r_idx   <= r_idx + SIZE_W'(1);
                    if (!w_has_below) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_alive   <= r_alive;
                        r_o_status  <= r_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_alive     = r_o_alive;
    assign o_status    = r_o_status;

endmodule
